/* rtl/mt19937_keystream_cipher_top_assert.svh */
// assertion macros for the keystream cipher checker
`ifndef MT19937_KEYSTREAM_CIPHER_TOP_ASSERT_SVH
`define MT19937_KEYSTREAM_CIPHER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MTK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keystream cipher check failed");

// next-cycle implication, disabled while in reset
`define MTK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keystream cipher check failed");

// next-cycle implication that also checks across reset
`define MTK_ASSERT_RESET(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("keystream cipher reset check failed");

`endif

/* rtl/mtk_pkg.sv */
// shared types, constants and generator functions for the keystream cipher
package mtk_pkg;

  localparam int unsigned TW_N   = 624;
  localparam int unsigned TW_M   = 397;
  localparam int unsigned ADDR_W = $clog2(TW_N);
  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] INIT_MUL = 32'd1812433253;
  localparam logic [WORD_W-1:0] MATRIX   = 32'h9908B0DF;
  localparam logic [WORD_W-1:0] UPPER    = 32'h80000000;
  localparam logic [WORD_W-1:0] LOWER    = 32'h7FFFFFFF;
  localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C5680;
  localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC60000;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic REQ_SEED = 1'b0;

  typedef enum logic [1:0] {
    OP_SEED,
    OP_DRAW,
    OP_UNSEEDED
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } mtk_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEED,
    BK_CALC
  } bk_state_t;

  function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] i);
    return (i == ADDR_W'(TW_N - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] far_addr(input logic [ADDR_W-1:0] i);
    return (i < ADDR_W'(TW_N - TW_M)) ? i + ADDR_W'(TW_M) : i - ADDR_W'(TW_N - TW_M);
  endfunction

  function automatic logic [WORD_W-1:0] seed_step(input logic [WORD_W-1:0] prev,
                                                  input logic [ADDR_W-1:0] k);
    logic [WORD_W-1:0] x;
    x = prev ^ (prev >> 30);
    return WORD_W'(INIT_MUL * x) + WORD_W'(k);
  endfunction

  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] cur,
                                              input logic [WORD_W-1:0] nxt,
                                              input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = (cur & UPPER) | (nxt & LOWER);
    v = far ^ (y >> 1);
    if (y[0]) v = v ^ MATRIX;
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* rtl/mtk_if.sv */
// valid/ready channel interfaces for requests and results

interface mtk_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_in;

  modport source (output valid, output req_type, output data_in, input ready);
  modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface mtk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       not_seeded;

  modport source (output valid, output data_out, output not_seeded, input ready);
  modport sink   (input valid, input data_out, input not_seeded, output ready);
endinterface

/* rtl/mtk_ram.sv */
// generic ram, one write port and two registered read ports
module mtk_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 624,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

/* rtl/mtk_queue.sv */
// small command queue between the front and back ends
module mtk_queue import mtk_pkg::*; #(
  parameter  int unsigned DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  mtk_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output mtk_cmd_t pop_data
);

  mtk_cmd_t      mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

/* rtl/mtk_front.sv */
// front end: takes requests, holds the seed register and tags each command
module mtk_front import mtk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mtk_in_if.sink            in_ch,
  input  logic              cfg_wr_en,
  input  logic [WORD_W-1:0] cfg_wr_data,
  output logic [WORD_W-1:0] seed,
  output mtk_cmd_t          cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);

  logic [WORD_W-1:0] seed_r, seed_nxt;
  logic              seeded_r, seeded_nxt;
  logic              accept;

  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid;
  assign accept      = in_ch.valid && cmd_ready;
  assign seed        = seed_r;

  always_comb begin
    cmd.data = in_ch.data_in;
    if (in_ch.req_type == REQ_SEED) cmd.op = OP_SEED;
    else if (seeded_r)              cmd.op = OP_DRAW;
    else                            cmd.op = OP_UNSEEDED;

    // seeded state follows transaction order, so the back end never needs it
    seeded_nxt = seeded_r || (accept && (in_ch.req_type == REQ_SEED));
    seed_nxt   = cfg_wr_en ? cfg_wr_data : seed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      seeded_r <= 1'b0;
    end else begin
      seed_r   <= seed_nxt;
      seeded_r <= seeded_nxt;
    end
  end

endmodule

/* rtl/mtk_back.sv */
// back end: seeds the state ram, twists one word per draw and tempers it
module mtk_back import mtk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mtk_cmd_t          cmd,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [WORD_W-1:0] seed,
  mtk_out_if.source         out_ch
);

  bk_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [WORD_W-1:0] prev_r, prev_nxt;
  logic [WORD_W-1:0] cache_r, cache_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_ns_r, out_ns_nxt;

  logic              out_free;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata_a, rdata_b;
  logic [WORD_W-1:0] twisted, tempered;

  mtk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TW_N)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (next_addr(idx_r)),
    .raddr_b (far_addr(idx_r)),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign out_free        = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.not_seeded = out_ns_r;

  // lazy twist: words below idx are already twisted this round, the rest are not
  assign twisted  = twist(cache_r, rdata_a, rdata_b);
  assign tempered = temper(twisted);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    prev_nxt      = prev_r;
    cache_nxt     = cache_r;
    byte_nxt      = byte_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_ns_nxt    = out_ns_r;
    cmd_ready     = 1'b0;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = twisted;

    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_SEED: begin
              cmd_ready = 1'b1;
              we        = 1'b1;
              waddr     = '0;
              wdata     = seed;
              prev_nxt  = seed;
              cache_nxt = seed;
              k_nxt     = ADDR_W'(1);
              idx_nxt   = '0;
              state_nxt = BK_SEED;
            end
            OP_DRAW: begin
              // ram reads for this draw are issued now, data lands next cycle
              cmd_ready = 1'b1;
              byte_nxt  = cmd.data;
              state_nxt = BK_CALC;
            end
            OP_UNSEEDED: begin
              if (out_free) begin
                cmd_ready     = 1'b1;
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
                out_ns_nxt    = 1'b1;
              end
            end
            default: cmd_ready = 1'b1;
          endcase
        end
      end
      BK_SEED: begin
        we       = 1'b1;
        waddr    = k_r;
        wdata    = seed_step(prev_r, k_r);
        prev_nxt = wdata;
        if (k_r == ADDR_W'(TW_N - 1)) state_nxt = BK_IDLE;
        else                          k_nxt     = k_r + 1'b1;
      end
      BK_CALC: begin
        if (out_free) begin
          we            = 1'b1;
          waddr         = idx_r;
          wdata         = twisted;
          out_valid_nxt = 1'b1;
          out_data_nxt  = byte_r ^ tempered[7:0];
          out_ns_nxt    = 1'b0;
          cache_nxt     = rdata_a;
          idx_nxt       = next_addr(idx_r);
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    prev_r     <= prev_nxt;
    cache_r    <= cache_nxt;
    byte_r     <= byte_nxt;
    out_data_r <= out_data_nxt;
    out_ns_r   <= out_ns_nxt;
  end

endmodule

/* rtl/mt19937_keystream_cipher_top.sv */
// top level of the mt19937 keystream byte cipher
// data byte: command queue, back end idle and calc states, then result register
// bytes wait on the registered ram read; the back end serves one byte at a time
// reseed: holds the back end for the table fill, one word written per cycle
// reset clears control and the seed register; the state ram is not cleared
module mt19937_keystream_cipher_top import mtk_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mtk_in_if.sink            in_ch,
  mtk_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [WORD_W-1:0] cfg_wr_data
);

  mtk_cmd_t          push_cmd, pop_cmd;
  logic              push_valid, push_ready;
  logic              pop_valid, pop_ready;
  logic [WORD_W-1:0] seed;

  mtk_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .seed        (seed),
    .cmd         (push_cmd),
    .cmd_valid   (push_valid),
    .cmd_ready   (push_ready)
  );

  mtk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_cmd)
  );

  mtk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pop_cmd),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .seed      (seed),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/mtk_checker.sv */
// port-level checker for the keystream cipher, bound to the top level
`include "mt19937_keystream_cipher_top_assert.svh"

module mtk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data,
  input logic       out_not_seeded
);

  logic [8:0] out_payload;

  assign out_payload = {out_data, out_not_seeded};

  `MTK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `MTK_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_payload))
  // an unseeded result never carries keystream
  `MTK_ASSERT_IMPL(a_unseeded_zero, clk, rst_n, out_valid && out_not_seeded, out_data == 8'd0)
  `MTK_ASSERT_RESET(a_reset_quiet, clk, !rst_n, !out_valid)

endmodule

bind mt19937_keystream_cipher_top mtk_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_data       (out_ch.data_out),
  .out_not_seeded (out_ch.not_seeded)
);

/* tb/sv/mtk_cipher_checker.sv */
// checker for the keystream cipher: predicts each result byte and compares it on the result channel
module mtk_cipher_checker import mtk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mtk_in_if                 in_ch,
  mtk_out_if                out_ch,
  input  logic              cfg_wr_en,
  input  logic [WORD_W-1:0] cfg_wr_data,
  output int unsigned       pending_bytes,
  output int unsigned       mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data_out;
    logic       not_seeded;
  } cipher_byte_t;

  logic [WORD_W-1:0] seed_shadow;
  logic [WORD_W-1:0] mt_state [TW_N];
  int unsigned       draw_pos;
  bit                keyed;
  cipher_byte_t      expected_bytes [$];

  function automatic void reload_state(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] w;
    mt_state[0] = s;
    for (int k = 1; k < TW_N; k++) begin
      w = mt_state[k-1];
      mt_state[k] = INIT_MUL * (w ^ (w >> 30)) + WORD_W'(k);
    end
    draw_pos = 0;
    keyed = 1'b1;
  endfunction

  function automatic void regenerate_block();
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    for (int k = 0; k < TW_N; k++) begin
      y = (mt_state[k] & UPPER) | (mt_state[(k + 1) % TW_N] & LOWER);
      v = mt_state[(k + TW_M) % TW_N] ^ (y >> 1);
      if (y[0]) v = v ^ MATRIX;
      mt_state[k] = v;
    end
  endfunction

  function automatic logic [7:0] next_key_byte();
    logic [WORD_W-1:0] t;
    // whole table is regenerated when the draw position wraps
    if (draw_pos == 0) regenerate_block();
    t = mt_state[draw_pos];
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    draw_pos = (draw_pos + 1) % TW_N;
    return t[7:0];
  endfunction

  always @(posedge clk) begin
    cipher_byte_t want;
    if (!rst_n) begin
      seed_shadow = '0;
      draw_pos = 0;
      keyed = 1'b0;
      mismatch_count = 0;
      expected_bytes.delete();
    end else begin
      // compare before pushing so a result can never match its own request
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result transaction: data_out %02h not_seeded %0b",
                 out_ch.data_out, out_ch.not_seeded);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.data_out !== want.data_out) begin
            $error("data_out mismatch: expected %02h actual %02h",
                   want.data_out, out_ch.data_out);
            mismatch_count++;
          end
          if (out_ch.not_seeded !== want.not_seeded) begin
            $error("not_seeded mismatch: expected %0b actual %0b",
                   want.not_seeded, out_ch.not_seeded);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.req_type == REQ_SEED) begin
          reload_state(seed_shadow);
        end else if (!keyed) begin
          want.data_out = 8'h00;
          want.not_seeded = 1'b1;
          expected_bytes.push_back(want);
        end else begin
          want.data_out = in_ch.data_in ^ next_key_byte();
          want.not_seeded = 1'b0;
          expected_bytes.push_back(want);
        end
      end
      if (cfg_wr_en) seed_shadow = cfg_wr_data;
    end
    pending_bytes = expected_bytes.size();
  end

endmodule

/* tb/sv/tb.sv */
// testbench top for the keystream cipher: clock, reset, stimulus phases and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtk_pkg::*;

  localparam logic        REQ_BYTE    = ~REQ_SEED;
  // a queued reseed holds the back end for a full table fill each
  localparam int unsigned SEED_SETTLE = (QUEUE_DEPTH_DEF + 2) * TW_N;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [WORD_W-1:0] cfg_wr_data;
  logic              req_fire;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       pending_bytes;
  int unsigned       mismatch_count;

  mtk_in_if  in_ch ();
  mtk_out_if out_ch ();

  mt19937_keystream_cipher_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  mtk_cipher_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .pending_bytes  (pending_bytes),
    .mismatch_count (mismatch_count)
  );

  always #5 clk = ~clk;

  // request transaction seen at the last rising edge, read at the falling edge
  always @(posedge clk) begin
    req_fire <= in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin
    out_ch.ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(input logic req, input logic [7:0] byte_val);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.req_type = req;
    in_ch.data_in  = byte_val;
    do @(negedge clk); while (!req_fire);
  endtask

  task automatic idle_until_drained(input int unsigned settle);
    in_ch.valid = 1'b0;
    while (pending_bytes != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] value);
    idle_until_drained(SEED_SETTLE);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_SEED;
    in_ch.data_in  = 8'h00;
    out_ch.ready   = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // bytes before any reseed come back flagged
    send_request(REQ_BYTE, 8'h00);
    send_request(REQ_BYTE, 8'hFF);
    // reseed from the reset value of the seed
    send_request(REQ_SEED, 8'hFF);
    send_request(REQ_BYTE, 8'h00);
    send_request(REQ_BYTE, 8'hFF);
    send_request(REQ_BYTE, 8'hA5);
    // a new seed only counts from the next reseed
    write_seed('1);
    send_request(REQ_BYTE, 8'h3C);
    send_request(REQ_SEED, 8'h00);
    send_request(REQ_BYTE, 8'h01);
    send_request(REQ_BYTE, 8'h80);
    send_request(REQ_BYTE, 8'h7E);
    // back-to-back reseeds while already keyed
    write_seed(32'd5489);
    send_request(REQ_SEED, 8'h55);
    send_request(REQ_SEED, 8'hAA);
    send_request(REQ_BYTE, 8'h00);
    send_request(REQ_BYTE, 8'hFF);
    send_request(REQ_BYTE, 8'h5A);
    write_seed('0);
    send_request(REQ_SEED, 8'h00);
    send_request(REQ_BYTE, 8'hC3);
    send_request(REQ_BYTE, 8'h18);

    for (int phase = 0; phase < 4; phase++) begin
      write_seed($urandom());
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (phase % 2 == 0) send_request(REQ_SEED, 8'($urandom()));
      // rare reseeds leave long runs so the draw position wraps past the end of the table
      for (int n = 0; n < 400; n++) begin
        if (phase == 1 && n == 200) idle_until_drained(0);
        if ($urandom_range(299) == 0) send_request(REQ_SEED, 8'($urandom()));
        else send_request(REQ_BYTE, 8'($urandom()));
      end
    end

    idle_until_drained(64);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/mtk_pkg.sv
rtl/mtk_if.sv
rtl/mtk_ram.sv
rtl/mtk_queue.sv
rtl/mtk_front.sv
rtl/mtk_back.sv
rtl/mt19937_keystream_cipher_top.sv
rtl/mtk_checker.sv
tb/sv/mtk_cipher_checker.sv
tb/sv/tb.sv
